// ===== rtl/ccpp_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ccpp_pkg
// Shared types, codes and the tag decode table for the constant-pool parser.
// -----------------------------------------------------------------------------
package ccpp_pkg;

   localparam logic [1:0] PH_TAG     = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_TEXT    = 2'd2;
   localparam logic [1:0] PH_ERROR   = 2'd3;

   localparam logic [1:0] KIND_ENTRY = 2'd0;
   localparam logic [1:0] KIND_PAD   = 2'd1;
   localparam logic [1:0] KIND_TEXT  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [7:0] TAG_UTF8           = 8'd1;
   localparam logic [7:0] TAG_INTEGER        = 8'd3;
   localparam logic [7:0] TAG_FLOAT          = 8'd4;
   localparam logic [7:0] TAG_LONG           = 8'd5;
   localparam logic [7:0] TAG_DOUBLE         = 8'd6;
   localparam logic [7:0] TAG_CLASS          = 8'd7;
   localparam logic [7:0] TAG_STRING         = 8'd8;
   localparam logic [7:0] TAG_FIELDREF       = 8'd9;
   localparam logic [7:0] TAG_METHODREF      = 8'd10;
   localparam logic [7:0] TAG_IFACE_METHODREF = 8'd11;
   localparam logic [7:0] TAG_NAME_AND_TYPE  = 8'd12;
   localparam logic [7:0] TAG_METHOD_HANDLE  = 8'd15;
   localparam logic [7:0] TAG_METHOD_TYPE    = 8'd16;
   localparam logic [7:0] TAG_INVOKE_DYNAMIC = 8'd18;

   localparam logic [15:0] START_INDEX_RESET = 16'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic       pool_start;
      logic [7:0] pool_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] entry_index;
      logic [7:0]  tag;
      logic [63:0] value_bits;
      logic [15:0] first_ref;
      logic [15:0] second_ref;
      logic [7:0]  ref_kind;
      logic [15:0] text_length;
      logic [7:0]  text_byte;
      logic        last;
   } result_type;

   typedef struct packed {
      logic push0;
      logic push1;
   } push_type;

   function automatic logic [3:0] payload_size(input logic [7:0] t);
      logic [3:0] sz;
      case (t)
         TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: sz = 4'd2;
         TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
         TAG_IFACE_METHODREF, TAG_NAME_AND_TYPE, TAG_INVOKE_DYNAMIC: sz = 4'd4;
         TAG_LONG, TAG_DOUBLE: sz = 4'd8;
         TAG_METHOD_HANDLE: sz = 4'd3;
         default: sz = 4'd0;
      endcase
      return sz;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ccpp_in_stage.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ccpp_in_stage
// Input register: holds one pool byte until the parser takes it.
// -----------------------------------------------------------------------------
module ccpp_in_stage
   import ccpp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   input  wire logic     consume,
   output logic          item_valid,
   output item_type      item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || consume;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !consume);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ccpp_parser.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ccpp_parser
// Tag/payload/text state machine; builds up to two result records per byte.
// -----------------------------------------------------------------------------
module ccpp_parser
   import ccpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  wire item_type    item,
   input  wire logic [15:0] start_index,
   input  wire logic        space,
   output logic             consume,
   output push_type         push,
   output result_type       rec0,
   output result_type       rec1
);

   logic [1:0]  phase_ff, phase_in, phase_cur;
   logic [7:0]  tag_ff, tag_in, tag_cur;
   logic [3:0]  left_ff, left_in, left_cur, left_dec, sz;
   logic [15:0] text_ff, text_in, text_cur;
   logic [63:0] acc_ff, acc_in, acc_cur, acc_shift;
   logic [15:0] cnt_ff, cnt_in, cnt_cur;
   logic [15:0] lo16;
   logic [7:0]  b;
   logic        n0, n1;

   assign b         = item.pool_byte;
   assign phase_cur = item.pool_start ? PH_TAG : phase_ff;
   assign tag_cur   = item.pool_start ? 8'd0 : tag_ff;
   assign left_cur  = item.pool_start ? 4'd0 : left_ff;
   assign text_cur  = item.pool_start ? 16'd0 : text_ff;
   assign acc_cur   = item.pool_start ? 64'd0 : acc_ff;
   assign cnt_cur   = item.pool_start ? start_index : cnt_ff;
   assign acc_shift = {acc_cur[55:0], b};
   assign left_dec  = left_cur - 4'd1;
   assign lo16      = acc_shift[15:0];
   assign sz        = payload_size(b);

   always_comb begin
      phase_in = phase_cur;
      tag_in   = tag_cur;
      left_in  = left_cur;
      text_in  = text_cur;
      acc_in   = acc_cur;
      cnt_in   = cnt_cur;
      rec0     = '0;
      rec1     = '0;
      n0       = 1'b0;
      n1       = 1'b0;
      case (phase_cur)
         PH_TAG: begin
            if (sz == 4'd0) begin
               rec0.kind        = KIND_ERROR;
               rec0.entry_index = cnt_cur;
               rec0.tag         = b;
               rec0.last        = 1'b1;
               n0               = 1'b1;
               phase_in         = PH_ERROR;
            end else begin
               tag_in   = b;
               left_in  = sz;
               acc_in   = 64'd0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            acc_in  = acc_shift;
            left_in = left_dec;
            if (left_dec == 4'd0) begin
               phase_in         = PH_TAG;
               acc_in           = 64'd0;
               cnt_in           = cnt_cur + 16'd1;
               rec0.kind        = KIND_ENTRY;
               rec0.entry_index = cnt_cur;
               rec0.tag         = tag_cur;
               rec0.last        = 1'b1;
               n0               = 1'b1;
               case (tag_cur)
                  TAG_UTF8: begin
                     rec0.text_length = lo16;
                     text_in          = lo16;
                     if (lo16 != 16'd0) begin
                        phase_in = PH_TEXT;
                     end
                  end
                  TAG_INTEGER, TAG_FLOAT: begin
                     rec0.value_bits = {32'd0, acc_shift[31:0]};
                  end
                  TAG_LONG, TAG_DOUBLE: begin
                     rec0.value_bits  = acc_shift;
                     rec0.last        = 1'b0;
                     rec1.kind        = KIND_PAD;
                     rec1.entry_index = cnt_cur + 16'd1;
                     rec1.last        = 1'b1;
                     n1               = 1'b1;
                     cnt_in           = cnt_cur + 16'd2;
                  end
                  TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: begin
                     rec0.first_ref = lo16;
                  end
                  TAG_METHOD_HANDLE: begin
                     rec0.first_ref = lo16;
                     rec0.ref_kind  = acc_shift[23:16];
                  end
                  default: begin
                     rec0.first_ref  = acc_shift[31:16];
                     rec0.second_ref = lo16;
                  end
               endcase
            end
         end
         PH_TEXT: begin
            rec0.kind        = KIND_TEXT;
            rec0.entry_index = cnt_cur - 16'd1;
            rec0.tag         = TAG_UTF8;
            rec0.text_byte   = b;
            rec0.last        = 1'b1;
            n0               = 1'b1;
            text_in          = text_cur - 16'd1;
            if (text_cur == 16'd1) begin
               phase_in = PH_TAG;
            end
         end
         default: begin
         end
      endcase
   end

   assign consume    = item_valid && space;
   assign push.push0 = consume && n0;
   assign push.push1 = consume && n1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         tag_ff   <= 8'd0;
         left_ff  <= 4'd0;
         text_ff  <= 16'd0;
         acc_ff   <= 64'd0;
         cnt_ff   <= START_INDEX_RESET;
      end else if (consume) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         left_ff  <= left_in;
         text_ff  <= text_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ccpp_out_queue.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ccpp_out_queue
// Small result queue: takes one or two records a cycle, drains one a cycle while out_ready is high.
// -----------------------------------------------------------------------------
module ccpp_out_queue
   import ccpp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   input  wire result_type rec0,
   input  wire result_type rec1,
   output logic            space,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_rec
);

   localparam logic [QUEUE_AW:0] FREE_LIMIT = (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);

   result_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                pop;

   assign out_valid = count_ff != '0;
   assign out_rec   = mem_ff[rd_ptr_ff];
   assign space     = count_ff <= FREE_LIMIT;
   assign pop       = out_valid && out_ready;

   assign wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.push0) + QUEUE_AW'(push.push1);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
   assign count_in  = count_ff + (QUEUE_AW + 1)'(push.push0) + (QUEUE_AW + 1)'(push.push1)
                      - (QUEUE_AW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= rec0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_ff + QUEUE_AW'(1)] <= rec1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/class_constant_pool_parser.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// class_constant_pool_parser
// Byte-serial class-file constant-pool parser with entry, padding, text and
// error results.
// -----------------------------------------------------------------------------
// channel   dir  handshake          payload
// req_      in   tvalid/tready      tdata: pool_byte; tuser: pool_start
// rsp_      out  tvalid/tready      tdata: record fields; tuser: kind; tlast: last
// csr_      in   wr_en              wr_data: start_index
//
// One byte per cycle while the queue has space: input register, combinational decode, result queue.
// Each result is decoded from the input register and written to the queue before its rsp_ transfer.
// Long and double entries push two results at once; the four-entry queue
// drains one per cycle, so req_tready stays high while rsp_tready does.
// Reset is synchronous; start_index returns to 1.
// A stalled rsp_ side stops decode once three results wait, then drops req_tready.
// -----------------------------------------------------------------------------
module class_constant_pool_parser
   import ccpp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] pool_byte
   input  wire logic         req_tuser,   // [0] pool_start
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [15:0] entry_index, [23:16] tag, [87:24] value_bits, [103:88] first_ref,
   // [119:104] second_ref, [127:120] ref_kind, [143:128] text_length,
   // [151:144] text_byte
   output logic [151:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,   // [1:0] kind
   output logic              rsp_tlast,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);

   logic [15:0] start_index_ff;
   item_type    in_item, item;
   logic        item_valid, consume, space;
   push_type    push;
   result_type  rec0, rec1, out_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_index_ff <= START_INDEX_RESET;
      end else if (csr_wr_en) begin
         start_index_ff <= csr_wr_data;
      end
   end

   assign in_item.pool_byte  = req_tdata;
   assign in_item.pool_start = req_tuser;

   ccpp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   ccpp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .start_index (start_index_ff),
      .space       (space),
      .consume     (consume),
      .push        (push),
      .rec0        (rec0),
      .rec1        (rec1)
   );

   ccpp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rec0      (rec0),
      .rec1      (rec1),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tdata = {out_rec.text_byte, out_rec.text_length, out_rec.ref_kind,
                       out_rec.second_ref, out_rec.first_ref, out_rec.value_bits,
                       out_rec.tag, out_rec.entry_index};
   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.last;

   a_pair_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0 && !rec0.last && rec1.last)
      else $error("padding record pushed without its entry record");

   a_pad_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAD |-> rsp_tlast && rsp_tdata[23:16] == 8'd0)
      else $error("padding result not last or has a tag");

   a_text_tagged: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TEXT |-> rsp_tlast && rsp_tdata[23:16] == TAG_UTF8)
      else $error("text byte result malformed");

   a_push_on_consume: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> consume && item_valid)
      else $error("result pushed without a consumed byte");

endmodule
`default_nettype wire
